// File: hdl/kmp_pkg.sv
package kmp_pkg;

  // Fixed field widths
  localparam int CH_W  = 8;
  localparam int OUT_W = 32;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // Request kinds
  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_TEXT    = 1'b1;

  // Sequencer steps
  typedef enum logic [1:0] {
    UC_IDLE = 2'd0,
    UC_CMP  = 2'd1,
    UC_EMIT = 2'd2
  } uc_step_t;

  // Branch conditions
  typedef enum logic [2:0] {
    COND_NONE     = 3'd0,
    COND_START    = 3'd1,
    COND_FALLBACK = 3'd2,
    COND_FULL     = 3'd3,
    COND_OUT_BUSY = 3'd4
  } uc_cond_t;

  // One control word per step
  typedef struct packed {
    logic     rdy;
    logic     cmp;
    logic     emit;
    uc_cond_t c1;
    uc_step_t t1;
    uc_cond_t c2;
    uc_step_t t2;
    uc_step_t seq;
  } uc_word_t;

  // Control store
  function automatic uc_word_t uc_rom(input uc_step_t s);
    uc_word_t w;
    unique case (s)
      UC_IDLE: w = '{rdy: 1'b1, cmp: 1'b0, emit: 1'b0,
                     c1: COND_START, t1: UC_CMP,
                     c2: COND_NONE, t2: UC_IDLE, seq: UC_IDLE};
      UC_CMP:  w = '{rdy: 1'b0, cmp: 1'b1, emit: 1'b0,
                     c1: COND_FALLBACK, t1: UC_CMP,
                     c2: COND_FULL, t2: UC_EMIT, seq: UC_IDLE};
      UC_EMIT: w = '{rdy: 1'b0, cmp: 1'b0, emit: 1'b1,
                     c1: COND_OUT_BUSY, t1: UC_EMIT,
                     c2: COND_NONE, t2: UC_IDLE, seq: UC_IDLE};
      default: w = '{rdy: 1'b0, cmp: 1'b0, emit: 1'b0,
                     c1: COND_NONE, t1: UC_IDLE,
                     c2: COND_NONE, t2: UC_IDLE, seq: UC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/kmp_if.sv
interface kmp_in_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [kmp_pkg::CH_W-1:0] ch;
  logic                     restart;

  modport source (output valid, req_type, ch, restart, input ready);
  modport sink   (input valid, req_type, ch, restart, output ready);
endinterface

interface kmp_out_if;
  logic                      valid;
  logic                      ready;
  logic [kmp_pkg::OUT_W-1:0] match_start;

  modport source (output valid, match_start, input ready);
  modport sink   (input valid, match_start, output ready);
endinterface

// File: hdl/kmp_ram.sv
module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/kmp_stream_matcher_core.sv
// A first pattern byte, an ignored byte or text with no pattern is taken in UC_IDLE and
//   needs no search; otherwise the core steps through UC_CMP, repeating it for each
//   failure-table fallback. A full match moves to UC_EMIT, which holds while the previous
//   result still waits on out_chan, then registers the match start on out_chan.
// A new byte is taken only in UC_IDLE, so the core does not take the next byte before the
//   last one is through. Reset (rst_n low, synchronous) clears the control registers.
module kmp_stream_matcher_core #(
  parameter int PAT_MAX  = 256,
  parameter int POS_BITS = 32
) (
  input logic       clk,
  input logic       rst_n,
  kmp_in_if.sink    in_chan,
  kmp_out_if.source out_chan
);
  import kmp_pkg::*;

  localparam int LW = $clog2(PAT_MAX + 1);
  localparam int AW = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
  localparam int SW = (POS_BITS + 1 > OUT_W + 1) ? POS_BITS + 1 : OUT_W + 1;

  uc_step_t step_r, step_nxt;
  uc_word_t uw;

  logic [LW-1:0]       plen_r, plen_nxt;
  logic [LW-1:0]       build_r, build_nxt;
  logic [LW-1:0]       tp_r, tp_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [LW-1:0]       j_r, j_nxt;
  logic [CH_W-1:0]     c_r, c_nxt;
  logic                req_r, req_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_start_r, out_start_nxt;

  // RAM ports
  logic            ps_we, ft_we;
  logic [AW-1:0]   ps_waddr, ft_waddr, ps_raddr, ft_raddr;
  logic [CH_W-1:0] ps_wdata, ps_rdata;
  logic [LW-1:0]   ft_wdata, ft_rdata;

  // Accept-side values
  logic                acc, in_text;
  logic [LW-1:0]       plen_eff, tp_eff, j_start;
  logic [POS_BITS-1:0] pos_base, pos_inc;
  logic                need_search;

  // Compare-side values
  logic          hit, fallback, full, out_busy;
  logic [LW-1:0] j_adv, rd_j, rd_jm1;

  // Start position
  logic [SW-1:0]    posx, plx, start_w;
  logic [OUT_W-1:0] start_c;

  logic [7:0] cond_vec;
  logic       c1_hit, c2_hit;

  assign uw            = uc_rom(step_r);
  assign in_chan.ready = uw.rdy;
  assign acc           = in_chan.valid && uw.rdy;

  // Decode the incoming item
  always_comb begin
    in_text  = (in_chan.req_type == REQ_TEXT);
    plen_eff = (in_chan.restart && !in_text) ? '0 : plen_r;
    tp_eff   = in_chan.restart ? '0 : tp_r;
    pos_base = in_chan.restart ? '0 : pos_r;
    pos_inc  = (pos_base != '1) ? pos_base + POS_BITS'(1) : pos_base;
    if (in_text) begin
      j_start     = (tp_eff >= plen_r) ? '0 : tp_eff;
      need_search = (plen_r != '0);
    end else begin
      j_start     = build_r;
      need_search = (plen_eff != '0) && (plen_eff < LW'(PAT_MAX));
    end
  end

  // Evaluate one compare step
  always_comb begin
    hit      = (c_r == ps_rdata);
    fallback = (j_r != '0) && !hit;
    j_adv    = j_r + LW'(hit);
    full     = (req_r == REQ_TEXT) && !fallback && (j_adv == plen_r);
    out_busy = out_valid_r && !out_chan.ready;
  end

  // Start position of a full match, clamped to the output range
  always_comb begin
    posx    = SW'(pos_r) + SW'(1);
    plx     = SW'(plen_r);
    start_w = (posx <= plx) ? SW'(1) : posx - plx;
    start_c = (start_w > SW'(OUT_MAX)) ? OUT_MAX : start_w[OUT_W-1:0];
  end

  // Branch conditions
  always_comb begin
    cond_vec                = '0;
    cond_vec[COND_START]    = acc && need_search;
    cond_vec[COND_FALLBACK] = fallback;
    cond_vec[COND_FULL]     = full;
    cond_vec[COND_OUT_BUSY] = out_busy;
    c1_hit                  = cond_vec[uw.c1];
    c2_hit                  = cond_vec[uw.c2];
  end

  // Next step
  always_comb begin
    if (c1_hit) begin
      step_nxt = uw.t1;
    end else if (c2_hit) begin
      step_nxt = uw.t2;
    end else begin
      step_nxt = uw.seq;
    end
  end

  // Read address: start index, fallback target, or advanced index (last failure entry)
  always_comb begin
    unique case (step_r)
      UC_CMP:  rd_j = fallback ? ft_rdata : j_adv;
      UC_EMIT: rd_j = plen_r;
      default: rd_j = j_start;
    endcase
    rd_jm1   = rd_j - LW'(1);
    ps_raddr = rd_j[AW-1:0];
    ft_raddr = rd_jm1[AW-1:0];
  end

  // Datapath driven by the control word
  always_comb begin
    plen_nxt      = plen_r;
    build_nxt     = build_r;
    tp_nxt        = tp_r;
    pos_nxt       = pos_r;
    j_nxt         = j_r;
    c_nxt         = c_r;
    req_nxt       = req_r;
    out_valid_nxt = out_valid_r;
    out_start_nxt = out_start_r;
    ps_we         = 1'b0;
    ps_waddr      = plen_r[AW-1:0];
    ps_wdata      = c_r;
    ft_we         = 1'b0;
    ft_waddr      = plen_r[AW-1:0];
    ft_wdata      = j_adv;

    // Drop the result once transferred
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Take a new item
    if (uw.rdy && acc) begin
      c_nxt   = in_chan.ch;
      req_nxt = in_chan.req_type;
      j_nxt   = j_start;
      if (in_text) begin
        tp_nxt  = tp_eff;
        pos_nxt = pos_inc;
      end else begin
        if (in_chan.restart) begin
          plen_nxt  = '0;
          build_nxt = '0;
          tp_nxt    = '0;
          pos_nxt   = '0;
        end
        if (plen_eff == '0) begin
          ps_we     = 1'b1;
          ps_waddr  = '0;
          ps_wdata  = in_chan.ch;
          ft_we     = 1'b1;
          ft_waddr  = '0;
          ft_wdata  = '0;
          build_nxt = '0;
          plen_nxt  = LW'(1);
        end
      end
    end

    // Fall back or finish the item
    if (uw.cmp) begin
      if (fallback) begin
        j_nxt = ft_rdata;
      end else if (req_r == REQ_PATTERN) begin
        ps_we     = 1'b1;
        ft_we     = 1'b1;
        build_nxt = j_adv;
        plen_nxt  = plen_r + LW'(1);
      end else if (!full) begin
        tp_nxt = j_adv;
      end
    end

    // Publish a match and continue from its failure entry
    if (uw.emit && !out_busy) begin
      out_valid_nxt = 1'b1;
      out_start_nxt = start_c;
      tp_nxt        = ft_rdata;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= UC_IDLE;
      plen_r      <= '0;
      build_r     <= '0;
      tp_r        <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      plen_r      <= plen_nxt;
      build_r     <= build_nxt;
      tp_r        <= tp_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    j_r         <= j_nxt;
    c_r         <= c_nxt;
    req_r       <= req_nxt;
    out_start_r <= out_start_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.match_start = out_start_r;

  kmp_ram #(
    .WIDTH (CH_W),
    .DEPTH (PAT_MAX)
  ) u_pat_ram (
    .clk   (clk),
    .we    (ps_we),
    .waddr (ps_waddr),
    .wdata (ps_wdata),
    .raddr (ps_raddr),
    .rdata (ps_rdata)
  );

  kmp_ram #(
    .WIDTH (LW),
    .DEPTH (PAT_MAX)
  ) u_fail_ram (
    .clk   (clk),
    .we    (ft_we),
    .waddr (ft_waddr),
    .wdata (ft_wdata),
    .raddr (ft_raddr),
    .rdata (ft_rdata)
  );

`ifndef NO_ASSERTIONS
  a_plen_range: assert property (@(posedge clk) disable iff (!rst_n)
    plen_r <= LW'(PAT_MAX))
    else $error("pattern length beyond store size");

  a_build_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (plen_r != '0) |-> (build_r < plen_r))
    else $error("build prefix not below pattern length");

  a_text_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (plen_r != '0) |-> (tp_r < plen_r))
    else $error("text prefix not below pattern length");

  a_emit_text_only: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == UC_EMIT) |-> (req_r == REQ_TEXT))
    else $error("match emitted for a pattern byte");

  a_fallback_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == UC_CMP && fallback) |=> (j_r < $past(j_r)))
    else $error("failure fallback did not shorten the prefix");
`endif

endmodule
